// ===== hw/rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Word types and field codes shared by the tagged bit packer.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam logic [2:0] OP_BOOL   = 3'd0;
    localparam logic [2:0] OP_INT32  = 3'd1;
    localparam logic [2:0] OP_UINT32 = 3'd2;
    localparam logic [2:0] OP_RAW    = 3'd3;
    localparam logic [2:0] OP_FLUSH  = 3'd4;

    localparam int unsigned TAG_BITS = 5;
    localparam logic [TAG_BITS-1:0] TAG_BOOL   = 5'd1;
    localparam logic [TAG_BITS-1:0] TAG_INT32  = 5'd7;
    localparam logic [TAG_BITS-1:0] TAG_UINT32 = 5'd8;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        end_of_message;
        logic [15:0] message_bytes;
    } t_out_word;

endpackage

// ===== hw/rtl/tagged_bit_packer.sv =====
// ----------------------------------------------------------------------------
// tagged_bit_packer
// Packs bools, 32-bit words and raw bytes LSB first into a byte stream.
//
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one word per
// accepted edge. Output channel (o_out_valid / i_out_stall / o_out_word)
// delivers one byte result per accepted edge. i_cfg_we writes the tag
// enable from i_cfg_wdata; write it only while the block is idle.
// An accepted word is packed combinationally into a byte holding stage, which
// feeds the output register one byte per cycle unless the receiver stalls; the
// first result of a word thus passes through both stages. A word that completes
// at most one byte (or a flush) allows one word per cycle if not stalled; a
// word that completes k bytes occupies the holding stage until all k are out,
// up to five for a tagged 32-bit word, so the byte-wide output sets the rate.
// A new word is taken while the last byte of the previous one moves out.
// When the receiver stalls, the output word holds and the holding stage
// fills, which then stalls the input. Reset (synchronous, active low)
// clears pending bits, byte count, tag enable and both output stages.
// ----------------------------------------------------------------------------
module tagged_bit_packer
    import tbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic        r_tags;
    logic [6:0]  r_pend_bits, n_pend_bits;
    logic [2:0]  r_pend_cnt, n_pend_cnt;
    logic [15:0] r_total, n_total;

    logic [39:0] r_hold_acc;
    logic [2:0]  r_hold_cnt;
    logic        r_hold_eom;
    logic        r_hold_bvalid;
    logic [15:0] r_hold_msg;

    logic        r_out_valid;
    t_out_word   r_out;

    logic        out_free, move, hold_done, in_acc;
    logic [36:0] payload;
    logic [5:0]  len, nbits;
    logic [43:0] acc;
    logic [2:0]  nbytes;
    logic [43:0] resid;
    logic [16:0] total_sum;
    logic [16:0] total_inc;
    logic [15:0] flush_msg;
    logic        op_data;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign move      = (r_hold_cnt != 3'd0) && out_free;
    assign hold_done = (r_hold_cnt == 3'd0) || ((r_hold_cnt == 3'd1) && out_free);
    assign o_in_stall = !hold_done;
    assign in_acc    = i_in_valid && hold_done;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        payload = '0;
        len     = '0;
        op_data = 1'b1;
        case (i_in_word.operation)
            OP_BOOL: begin
                payload = {36'd0, i_in_word.value[0]};
                len     = 6'd1;
                if (r_tags) begin
                    payload = {payload[31:0], TAG_BOOL};
                    len     = len + 6'(TAG_BITS);
                end
            end
            OP_INT32: begin
                payload = {5'd0, i_in_word.value};
                len     = 6'd32;
                if (r_tags) begin
                    payload = {payload[31:0], TAG_INT32};
                    len     = len + 6'(TAG_BITS);
                end
            end
            OP_UINT32: begin
                payload = {5'd0, i_in_word.value};
                len     = 6'd32;
                if (r_tags) begin
                    payload = {payload[31:0], TAG_UINT32};
                    len     = len + 6'(TAG_BITS);
                end
            end
            OP_RAW: begin
                payload = {29'd0, i_in_word.value[7:0]};
                len     = 6'd8;
            end
            default: begin
                op_data = 1'b0;
            end
        endcase

        acc       = {37'd0, r_pend_bits} | ({7'd0, payload} << r_pend_cnt);
        nbits     = {3'd0, r_pend_cnt} + len;
        nbytes    = nbits[5:3];
        resid     = acc >> {nbytes, 3'b000};
        total_sum = {1'b0, r_total} + {14'd0, nbytes};
        total_inc = {1'b0, r_total} + 17'd1;
        flush_msg = (r_pend_cnt == 3'd0) ? r_total :
                    (total_inc[16] ? COUNT_MAX : total_inc[15:0]);

        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_total     = r_total;
        if (in_acc) begin
            if (i_in_word.operation == OP_FLUSH) begin
                n_pend_bits = '0;
                n_pend_cnt  = '0;
                n_total     = '0;
            end else if (op_data) begin
                n_pend_bits = resid[6:0];
                n_pend_cnt  = nbits[2:0];
                n_total     = total_sum[16] ? COUNT_MAX : total_sum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags      <= 1'b0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_total     <= '0;
            r_hold_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tags <= i_cfg_wdata;
            end
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_total     <= n_total;

            if (in_acc && i_in_word.operation == OP_FLUSH) begin
                r_hold_cnt <= 3'd1;
            end else if (in_acc && op_data) begin
                r_hold_cnt <= nbytes;
            end else if (move) begin
                r_hold_cnt <= r_hold_cnt - 3'd1;
            end

            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.operation == OP_FLUSH) begin
            r_hold_acc    <= {33'd0, r_pend_bits};
            r_hold_eom    <= 1'b1;
            r_hold_bvalid <= (r_pend_cnt != 3'd0);
            r_hold_msg    <= flush_msg;
        end else if (in_acc && op_data) begin
            r_hold_acc    <= acc[39:0];
            r_hold_eom    <= 1'b0;
            r_hold_bvalid <= 1'b1;
            r_hold_msg    <= '0;
        end else if (move) begin
            r_hold_acc    <= {8'd0, r_hold_acc[39:8]};
        end

        if (move) begin
            r_out.data_byte      <= r_hold_acc[7:0];
            r_out.byte_valid     <= r_hold_bvalid;
            r_out.end_of_message <= r_hold_eom;
            r_out.message_bytes  <= r_hold_msg;
        end
    end

endmodule

// ===== verif/tagged_bit_packer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tagged_bit_packer_checker
// Watches both word channels and the tag enable write of the packer. Every
// accepted input word is packed by an independent bit packer model into the
// byte results it must produce. Each accepted output word is checked field by
// field against the oldest of those results. The failure count and the number
// of results still awaited go back to the testbench top.
// ----------------------------------------------------------------------------
module tagged_bit_packer_checker
    import tbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_bytes_awaited
);

    t_out_word   byte_q[$];
    logic        tags_on;
    logic [6:0]  held_bits;
    logic [2:0]  held_count;
    logic [15:0] bytes_sent;
    int          fail_total;

    initial begin
        o_fail_count    = 0;
        o_bytes_awaited = 0;
        fail_total      = 0;
    end

    function automatic logic [15:0] count_up(input logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    task automatic pack_word(input t_in_word w);
        logic [63:0]         payload;
        logic [63:0]         acc;
        logic [TAG_BITS-1:0] tag;
        int unsigned         len;
        int unsigned         nbits;
        t_out_word           r;
        if (w.operation == OP_FLUSH) begin
            r = '0;
            r.end_of_message = 1'b1;
            if (held_count != 3'd0) begin
                r.data_byte     = {1'b0, held_bits};
                r.byte_valid    = 1'b1;
                r.message_bytes = count_up(bytes_sent);
            end else begin
                r.message_bytes = bytes_sent;
            end
            byte_q.push_back(r);
            held_bits  = '0;
            held_count = '0;
            bytes_sent = '0;
            return;
        end
        if (w.operation > OP_FLUSH)
            return;
        case (w.operation)
            OP_BOOL: begin
                payload = {63'd0, w.value[0]};
                len     = 1;
            end
            OP_RAW: begin
                payload = {56'd0, w.value[7:0]};
                len     = 8;
            end
            default: begin
                payload = {32'd0, w.value};
                len     = 32;
            end
        endcase
        if (tags_on && w.operation != OP_RAW) begin
            case (w.operation)
                OP_BOOL:  tag = TAG_BOOL;
                OP_INT32: tag = TAG_INT32;
                default:  tag = TAG_UINT32;
            endcase
            payload = (payload << TAG_BITS) | tag;
            len     = len + TAG_BITS;
        end
        acc   = {57'd0, held_bits} | (payload << held_count);
        nbits = held_count + len;
        while (nbits >= 8) begin
            r               = '0;
            r.data_byte     = acc[7:0];
            r.byte_valid    = 1'b1;
            byte_q.push_back(r);
            bytes_sent = count_up(bytes_sent);
            acc        = acc >> 8;
            nbits      = nbits - 8;
        end
        held_bits  = acc[6:0];
        held_count = nbits[2:0];
    endtask

    task automatic check_byte(input t_out_word got);
        t_out_word want;
        if (byte_q.size() == 0) begin
            $error("output word %h with no expected result", got);
            fail_total++;
            return;
        end
        want = byte_q.pop_front();
        if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
            fail_total++;
        end
        if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
            fail_total++;
        end
        if (got.end_of_message !== want.end_of_message) begin
            $error("end_of_message: expected %b, got %b",
                   want.end_of_message, got.end_of_message);
            fail_total++;
        end
        if (got.message_bytes !== want.message_bytes) begin
            $error("message_bytes: expected %0d, got %0d",
                   want.message_bytes, got.message_bytes);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tags_on    = 1'b0;
            held_bits  = '0;
            held_count = '0;
            bytes_sent = '0;
            byte_q.delete();
        end else begin
            if (i_cfg_we)
                tags_on = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                pack_word(i_in_word);
            if (i_out_valid && !i_out_stall)
                check_byte(i_out_word);
        end
        o_bytes_awaited <= byte_q.size();
        o_fail_count    <= fail_total;
    end

endmodule

// ===== verif/tagged_bit_packer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tagged_bit_packer_tb
// Drives the tagged bit packer with directed words (field extremes, every
// operation, flushes with and without a partial byte, ignored codes, a
// long message sent with no idling), then random words under both tag
// settings. Both channels idle and stall at random; the checker
// beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tagged_bit_packer_tb;
    import tbp_pkg::*;

    localparam logic [2:0] OP_LAST_CODE  = 3'd7;
    localparam int         LIMIT_CYCLES  = 2000000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         IDLE_PCT      = 33;
    localparam int         SAT_WORDS     = 40;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      cfg_we     = 1'b0;
    logic      cfg_wdata  = 1'b0;
    logic      in_valid   = 1'b0;
    logic      in_stall;
    t_in_word  in_word    = '0;
    logic      out_valid;
    logic      out_stall  = 1'b0;
    t_out_word out_word;

    int fail_count;
    int bytes_awaited;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int cycle_count  = 0;

    tagged_bit_packer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    tagged_bit_packer_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .o_fail_count    (fail_count),
        .o_bytes_awaited (bytes_awaited)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [31:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= {op, val};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold input off until every predicted byte is out, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bytes_awaited != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tags(input logic on);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_word();
        int          pick;
        int          vsel;
        logic [2:0]  op;
        logic [31:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            op = OP_FLUSH + 3'($urandom_range(1, 3));
        else if (pick < 12)
            op = OP_FLUSH;
        else if (pick < 40)
            op = OP_BOOL;
        else if (pick < 60)
            op = OP_INT32;
        else if (pick < 80)
            op = OP_UINT32;
        else
            op = OP_RAW;
        vsel = $urandom_range(0, 9);
        if (vsel == 0)
            val = '0;
        else if (vsel == 1)
            val = '1;
        else
            val = $urandom();
        send_word(op, val);
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;

        // untagged directed words
        write_tags(1'b0);
        send_word(OP_BOOL, 32'hFFFF_FFFE);
        send_word(OP_BOOL, 32'h0000_0001);
        send_word(OP_INT32, 32'h8000_0000);
        send_word(OP_UINT32, 32'hFFFF_FFFF);
        send_word(OP_RAW, 32'hFFFF_FF5A);
        send_word(OP_RAW, 32'h0000_0000);
        send_word(OP_FLUSH, 32'hFFFF_FFFF);
        send_word(OP_FLUSH, 32'h0000_0000);
        for (int c = OP_FLUSH + 1; c <= OP_LAST_CODE; c++)
            send_word(3'(c), 32'hFFFF_FFFF);
        send_word(OP_INT32, 32'h7FFF_FFFF);
        send_word(OP_RAW, 32'h0000_00FF);
        send_word(OP_FLUSH, 32'h0000_0000);

        // tagged directed words
        drain();
        write_tags(1'b1);
        send_word(OP_BOOL, 32'h0000_0001);
        send_word(OP_INT32, 32'h8000_0000);
        send_word(OP_UINT32, 32'hFFFF_FFFF);
        send_word(OP_RAW, 32'h0000_00A5);
        send_word(OP_BOOL, 32'hFFFF_FFFE);
        send_word(OP_FLUSH, 32'h0000_0000);

        // one long message, no idling on either side
        drain();
        write_tags(1'b0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_word(OP_BOOL, 32'h0000_0001);
        for (int i = 0; i < SAT_WORDS; i++)
            send_word(OP_UINT32, $urandom());
        send_word(OP_FLUSH, 32'h0000_0000);
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;

        // random words, tag setting alternating between phases
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            write_tags(phase % 2 == 0);
            for (int i = 0; i < 80; i++)
                send_random_word();
        end

        drain();
        if (fail_count == 0 && bytes_awaited == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== tagged_bit_packer.f =====
hw/rtl/tbp_pkg.sv
hw/rtl/tagged_bit_packer.sv
verif/tagged_bit_packer_checker.sv
verif/tagged_bit_packer_tb.sv
